FILE: hw/rtl/atd_pkg.sv
package atd_pkg;

   localparam int unsigned LevelWidth  = 13;
   localparam int unsigned ThreshWidth = 13;
   localparam int unsigned CountWidth  = 8;
   localparam int unsigned TimeWidth   = 48;
   localparam int unsigned PosWidth    = 8;
   localparam int unsigned SampleWidth = 16;
   localparam int unsigned LevelShift  = 3;
   localparam int unsigned CsrIdxWidth = 2;
   localparam int unsigned CsrDataWidth = 13;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_START_THRESHOLD = 2'd0,
      CSR_QUIET_THRESHOLD = 2'd1,
      CSR_QUIET_LENGTH    = 2'd2,
      CSR_MAX_LENGTH      = 2'd3
   } csr_index_type;

   localparam logic [ThreshWidth-1:0] StartThresholdReset = 13'd30;
   localparam logic [ThreshWidth-1:0] QuietThresholdReset = 13'd12;
   localparam logic [CountWidth-1:0]  QuietLengthReset    = 8'd6;
   localparam logic [CountWidth-1:0]  MaxLengthReset      = 8'd30;

   typedef struct packed {
      logic [ThreshWidth-1:0] start_threshold;
      logic [ThreshWidth-1:0] quiet_threshold;
      logic [CountWidth-1:0]  quiet_length;
      logic [CountWidth-1:0]  dur_limit;
   } cfg_type;

   typedef struct packed {
      logic [CountWidth-1:0] strength;
      logic [TimeWidth-1:0]  time_stamp;
      logic [PosWidth-1:0]   pos_x;
      logic [PosWidth-1:0]   pos_y;
   } result_type;

endpackage

FILE: hw/rtl/atd_csr.sv
module atd_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [atd_pkg::CsrIdxWidth-1:0]       csr_index,
   input  logic [atd_pkg::CsrDataWidth-1:0]      csr_wdata,
   output atd_pkg::cfg_type                      cfg
);
   import atd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_START_THRESHOLD: cfg_in.start_threshold = csr_wdata[ThreshWidth-1:0];
            CSR_QUIET_THRESHOLD: cfg_in.quiet_threshold = csr_wdata[ThreshWidth-1:0];
            CSR_QUIET_LENGTH:    cfg_in.quiet_length    = csr_wdata[CountWidth-1:0];
            CSR_MAX_LENGTH:      cfg_in.dur_limit       = csr_wdata[CountWidth-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_threshold <= StartThresholdReset;
         cfg_ff.quiet_threshold <= QuietThresholdReset;
         cfg_ff.quiet_length    <= QuietLengthReset;
         cfg_ff.dur_limit       <= MaxLengthReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: hw/rtl/atd_core.sv
module atd_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  step,
   input  atd_pkg::cfg_type                      cfg,
   input  logic signed [atd_pkg::SampleWidth-1:0] z_sample,
   input  logic [atd_pkg::TimeWidth-1:0]         sample_time,
   input  logic [atd_pkg::PosWidth-1:0]          position_x,
   input  logic [atd_pkg::PosWidth-1:0]          position_y,
   output logic                                  emit,
   output atd_pkg::result_type                   result
);
   import atd_pkg::*;

   logic signed [LevelWidth-1:0] prev_level_ff, prev_level_in;
   logic                         primed_ff;
   logic [CountWidth-1:0]        quiet_cnt_ff, quiet_cnt_in;
   logic [CountWidth-1:0]        dur_cnt_ff, dur_cnt_in;
   logic [TimeWidth-1:0]         start_time_ff, start_time_in;
   logic [PosWidth-1:0]          start_x_ff, start_x_in;
   logic [PosWidth-1:0]          start_y_ff, start_y_in;
   logic                         capture;

   logic signed [LevelWidth:0]   delta;
   logic [LevelWidth:0]          delta_abs;
   logic [ThreshWidth-1:0]       diff;
   logic [CountWidth-1:0]        quiet_eff, dur_eff;

   assign prev_level_in = z_sample[SampleWidth-1:LevelShift];

   always_comb begin
      delta     = {prev_level_in[LevelWidth-1], prev_level_in}
                - {prev_level_ff[LevelWidth-1], prev_level_ff};
      delta_abs = delta[LevelWidth] ? (LevelWidth+1)'(0) - delta : delta;
      diff      = primed_ff ? delta_abs[ThreshWidth-1:0] : '0;
      quiet_eff = primed_ff ? quiet_cnt_ff : '0;
      dur_eff   = primed_ff ? dur_cnt_ff : cfg.dur_limit;

      quiet_cnt_in  = quiet_eff;
      dur_cnt_in    = dur_eff;
      capture       = 1'b0;
      emit          = 1'b0;

      if (quiet_eff < cfg.quiet_length) begin
         if (dur_eff < cfg.dur_limit) begin
            dur_cnt_in = dur_eff + 8'd1;
         end
         if (diff < cfg.quiet_threshold) begin
            quiet_cnt_in = quiet_eff + 8'd1;
            emit = (quiet_cnt_in >= cfg.quiet_length) && (dur_cnt_in < cfg.dur_limit);
         end else begin
            quiet_cnt_in = '0;
         end
      end else if (diff >= cfg.start_threshold) begin
         quiet_cnt_in = '0;
         dur_cnt_in   = 8'd1;
         capture      = 1'b1;
      end

      start_time_in = capture ? sample_time : start_time_ff;
      start_x_in    = capture ? position_x : start_x_ff;
      start_y_in    = capture ? position_y : start_y_ff;

      result.strength   = dur_cnt_in - cfg.quiet_length;
      result.time_stamp = start_time_ff;
      result.pos_x      = start_x_ff;
      result.pos_y      = start_y_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_level_ff <= '0;
         primed_ff     <= 1'b0;
         quiet_cnt_ff  <= '0;
         dur_cnt_ff    <= '0;
      end else if (step) begin
         prev_level_ff <= prev_level_in;
         primed_ff     <= 1'b1;
         quiet_cnt_ff  <= quiet_cnt_in;
         dur_cnt_ff    <= dur_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         start_time_ff <= start_time_in;
         start_x_ff    <= start_x_in;
         start_y_ff    <= start_y_in;
      end
   end

endmodule

FILE: hw/rtl/accel_tap_detector_unit.sv
// channel | direction | fields                                   | handshake
// req     | in        | z_sample, sample_time, position_x/y      | req_valid / req_stall
// rsp     | out       | tap_strength, tap_time, tap_x, tap_y     | rsp_valid / rsp_stall
// csr     | in        | csr_index, csr_wdata                     | csr_wr_en
//
// One word per cycle sustained unless a stalled result holds the input register.
// Input register -> detector logic -> result register; the detector state updates as a
// word leaves the input register. Reset is synchronous and restores register defaults.
// A stalled result holds the input register and the detector state, tap or no tap.
module accel_tap_detector_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [atd_pkg::SampleWidth-1:0] req_z_sample,
   input  logic [atd_pkg::TimeWidth-1:0]          req_sample_time,
   input  logic [atd_pkg::PosWidth-1:0]           req_position_x,
   input  logic [atd_pkg::PosWidth-1:0]           req_position_y,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [atd_pkg::CountWidth-1:0]         rsp_tap_strength,
   output logic [atd_pkg::TimeWidth-1:0]          rsp_tap_time,
   output logic [atd_pkg::PosWidth-1:0]           rsp_tap_x,
   output logic [atd_pkg::PosWidth-1:0]           rsp_tap_y,
   input  logic                                   csr_wr_en,
   input  logic [atd_pkg::CsrIdxWidth-1:0]        csr_index,
   input  logic [atd_pkg::CsrDataWidth-1:0]       csr_wdata
);
   import atd_pkg::*;

   cfg_type    cfg;
   result_type result;
   logic       emit;
   logic       step;
   logic       in_load;
   logic       out_free;

   logic                          in_valid_ff;
   logic signed [SampleWidth-1:0] in_z_ff;
   logic [TimeWidth-1:0]          in_time_ff;
   logic [PosWidth-1:0]           in_x_ff, in_y_ff;

   logic       out_valid_ff, out_valid_in;
   result_type out_ff;

   atd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   atd_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .cfg         (cfg),
      .z_sample    (in_z_ff),
      .sample_time (in_time_ff),
      .position_x  (in_x_ff),
      .position_y  (in_y_ff),
      .emit        (emit),
      .result      (result)
   );

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign in_load   = req_valid && !req_stall;

   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      if (step) begin
         out_valid_in = emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_z_ff    <= req_z_sample;
         in_time_ff <= req_sample_time;
         in_x_ff    <= req_position_x;
         in_y_ff    <= req_position_y;
      end
      if (step && emit) begin
         out_ff <= result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_tap_strength = out_ff.strength;
   assign rsp_tap_time     = out_ff.time_stamp;
   assign rsp_tap_x        = out_ff.pos_x;
   assign rsp_tap_y        = out_ff.pos_y;

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import atd_pkg::*;

   localparam int LevelMax = 2 ** (LevelWidth - 1) - 1;
   localparam int LevelMin = -(2 ** (LevelWidth - 1));
   localparam int SettleCycles = 8;
   localparam int PhaseWords = 100;
   localparam logic [TimeWidth-1:0] TimeMax = '1;

   typedef enum {ROW_PREDICT, ROW_TAP, ROW_NONE} row_kind_type;
   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_type;

   typedef struct {
      int                    level;
      int                    low;
      logic [TimeWidth-1:0]  t_ms;
      logic [PosWidth-1:0]   x;
      logic [PosWidth-1:0]   y;
      row_kind_type          kind;
      result_type            tap;
   } directed_row_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic signed [SampleWidth-1:0]  req_z_sample = '0;
   logic [TimeWidth-1:0]           req_sample_time = '0;
   logic [PosWidth-1:0]            req_position_x = '0;
   logic [PosWidth-1:0]            req_position_y = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [CountWidth-1:0]          rsp_tap_strength;
   logic [TimeWidth-1:0]           rsp_tap_time;
   logic [PosWidth-1:0]            rsp_tap_x;
   logic [PosWidth-1:0]            rsp_tap_y;
   logic                           csr_wr_en = 1'b0;
   logic [CsrIdxWidth-1:0]         csr_index = '0;
   logic [CsrDataWidth-1:0]        csr_wdata = '0;

   // detector shadow state
   cfg_type                        tap_cfg = '{StartThresholdReset, QuietThresholdReset,
                                               QuietLengthReset, MaxLengthReset};
   logic signed [LevelWidth-1:0]   prev_level = '0;
   bit                             primed = 1'b0;
   logic [CountWidth-1:0]          quiet_cnt = '0;
   logic [CountWidth-1:0]          dur_cnt = '0;
   logic [TimeWidth-1:0]           start_t = '0;
   logic [PosWidth-1:0]            start_x = '0;
   logic [PosWidth-1:0]            start_y = '0;

   result_type                     expected_taps[$];
   int                             mismatches = 0;
   int                             words_sent = 0;
   int                             burst_left = 0;
   bit                             steady = 1'b0;
   int                             shape_level = 0;

   stall_mode_type                 stall_mode = STALL_NONE;
   int                             stall_left = 0;
   logic [15:0]                    stall_bits = '0;

   directed_row_type               dir_rows[24];

   accel_tap_detector_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_z_sample     (req_z_sample),
      .req_sample_time  (req_sample_time),
      .req_position_x   (req_position_x),
      .req_position_y   (req_position_y),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_tap_strength (rsp_tap_strength),
      .rsp_tap_time     (rsp_tap_time),
      .rsp_tap_x        (rsp_tap_x),
      .rsp_tap_y        (rsp_tap_y),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic bit detect_tap(input logic [SampleWidth-1:0] z,
         input logic [TimeWidth-1:0] t_ms, input logic [PosWidth-1:0] x,
         input logic [PosWidth-1:0] y, output result_type tap);
      logic signed [LevelWidth-1:0] lvl;
      int diff;
      bit fired;
      lvl = z[SampleWidth-1:LevelShift];
      fired = 1'b0;
      tap = '0;
      if (!primed) begin
         // first word: forced pass through a tap that can never be accepted
         primed = 1'b1;
         quiet_cnt = '0;
         dur_cnt = tap_cfg.dur_limit;
         diff = 0;
      end else begin
         diff = int'(lvl) - int'(prev_level);
         if (diff < 0) diff = -diff;
      end
      prev_level = lvl;
      if (quiet_cnt < tap_cfg.quiet_length) begin
         if (dur_cnt < tap_cfg.dur_limit) dur_cnt = dur_cnt + 8'd1;
         if (diff < int'(tap_cfg.quiet_threshold)) begin
            quiet_cnt = quiet_cnt + 8'd1;
            if (quiet_cnt >= tap_cfg.quiet_length && dur_cnt < tap_cfg.dur_limit) begin
               tap.strength = dur_cnt - tap_cfg.quiet_length;
               tap.time_stamp = start_t;
               tap.pos_x = start_x;
               tap.pos_y = start_y;
               fired = 1'b1;
            end
         end else begin
            quiet_cnt = '0;
         end
      end else if (diff >= int'(tap_cfg.start_threshold)) begin
         quiet_cnt = '0;
         dur_cnt = 8'd1;
         start_t = t_ms;
         start_x = x;
         start_y = y;
      end
      return fired;
   endfunction

   function automatic void check_field(input string name, input logic [TimeWidth-1:0] want,
         input logic [TimeWidth-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endfunction

   task automatic send_word(input logic [SampleWidth-1:0] z, input logic [TimeWidth-1:0] t_ms,
         input logic [PosWidth-1:0] x, input logic [PosWidth-1:0] y,
         output bit got, output result_type tap);
      int gap;
      if (burst_left == 0) begin
         gap = steady ? 0 : $urandom_range(0, 9);
         burst_left = $urandom_range(1, 40);
         if (gap > 0) begin
            @(negedge clock);
            req_valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_z_sample = z;
      req_sample_time = t_ms;
      req_position_x = x;
      req_position_y = y;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      got = detect_tap(z, t_ms, x, y, tap);
      burst_left--;
      words_sent++;
   endtask

   task automatic emit_level(input int lvl);
      bit got;
      result_type tap;
      if (lvl > LevelMax) lvl = LevelMax;
      if (lvl < LevelMin) lvl = LevelMin;
      send_word(16'(lvl * 8 + $urandom_range(0, 7)), 48'({$urandom, $urandom}),
                8'($urandom), 8'($urandom), got, tap);
      if (got) expected_taps.push_back(tap);
      shape_level = lvl;
   endtask

   task automatic emit_quiet();
      int mag;
      int top;
      top = int'(tap_cfg.quiet_threshold) - 1;
      if (top > 40) top = 40;
      mag = (top < 0) ? 0 : $urandom_range(0, top);
      emit_level($urandom_range(0, 1) ? shape_level + mag : shape_level - mag);
   endtask

   task automatic emit_loud();
      int mag;
      mag = int'(tap_cfg.quiet_threshold) + $urandom_range(0, 40);
      emit_level(shape_level < 0 ? shape_level + mag : shape_level - mag);
   endtask

   task automatic emit_spike();
      int jump;
      jump = int'(tap_cfg.start_threshold) + $urandom_range(0, 20);
      emit_level(shape_level < 0 ? shape_level + jump : shape_level - jump);
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      burst_left = 0;
      while (expected_taps.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CsrDataWidth-1:0] val);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(posedge clock);
      case (idx)
         CSR_START_THRESHOLD: tap_cfg.start_threshold = val;
         CSR_QUIET_THRESHOLD: tap_cfg.quiet_threshold = val;
         CSR_QUIET_LENGTH:    tap_cfg.quiet_length = val[CountWidth-1:0];
         CSR_MAX_LENGTH:      tap_cfg.dur_limit = val[CountWidth-1:0];
         default:             ;
      endcase
   endtask

   task automatic apply_settings(input cfg_type c);
      write_reg(CSR_START_THRESHOLD, c.start_threshold);
      write_reg(CSR_QUIET_THRESHOLD, c.quiet_threshold);
      write_reg(CSR_QUIET_LENGTH, {5'($urandom), c.quiet_length});
      write_reg(CSR_MAX_LENGTH, {5'($urandom), c.dur_limit});
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic run_phase(input int budget);
      int first;
      int body;
      int tail;
      int n;
      bit got;
      result_type tap;
      logic [SampleWidth-1:0] z;
      first = words_sent;
      steady = ($urandom_range(0, 3) == 0);
      while (words_sent - first < budget) begin
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 6)) begin
               z = 16'($urandom);
               send_word(z, 48'({$urandom, $urandom}), 8'($urandom), 8'($urandom), got, tap);
               if (got) expected_taps.push_back(tap);
               shape_level = int'($signed(z[SampleWidth-1:LevelShift]));
            end
         end else begin
            repeat ($urandom_range(0, 3)) emit_quiet();
            emit_spike();
            body = int'(tap_cfg.dur_limit) + 3;
            if (body > 45) body = 45;
            body = $urandom_range(0, body);
            for (n = 0; n < body; n++) begin
               if ($urandom_range(0, 1)) emit_loud();
               else emit_quiet();
            end
            tail = int'(tap_cfg.quiet_length) + $urandom_range(0, 2);
            repeat (tail) emit_quiet();
         end
      end
      // sometimes leave a tap open across the next register update
      if ($urandom_range(0, 1)) begin
         emit_spike();
         repeat ($urandom_range(0, 2)) emit_loud();
      end
      settle();
   endtask

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 2));
         stall_left = $urandom_range(10, 150);
         stall_bits = 16'($urandom) & 16'hFFFC;
      end
      stall_left--;
      stall_bits = {stall_bits[14:0], stall_bits[15]};
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= stall_bits[0];
         default:     rsp_stall <= stall_bits[0] | stall_bits[1];
      endcase
   end

   always @(posedge clock) begin : watch_taps
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_taps.size() == 0) begin
            $error("tap word with none expected: strength %0d time %0h x %0h y %0h",
                   rsp_tap_strength, rsp_tap_time, rsp_tap_x, rsp_tap_y);
            mismatches++;
         end else begin
            want = expected_taps.pop_front();
            check_field("tap_strength", want.strength, rsp_tap_strength);
            check_field("tap_time", want.time_stamp, rsp_tap_time);
            check_field("tap_x", want.pos_x, rsp_tap_x);
            check_field("tap_y", want.pos_y, rsp_tap_y);
         end
      end
   end

   initial begin
      #2000000;
      $display("accel_tap_detector_unit regression: fail");
      $finish;
   end

   initial begin : stimulus
      cfg_type plan[$];
      cfg_type ph;
      bit got;
      result_type tap;

      // reset settings: start 30, quiet 12, quiet length 6, max length 30
      dir_rows = '{
         '{ 4095, 7, 48'h0000_0000_1000, 8'h11, 8'h22, ROW_NONE, '0},   // power-up tap
         '{-4096, 0, 48'h0000_0000_1001, 8'h33, 8'h44, ROW_NONE, '0},
         '{-4096, 3, 48'h0000_0000_1002, 8'h55, 8'h66, ROW_PREDICT, '0},
         '{-4096, 5, 48'h0000_0000_1003, 8'h77, 8'h88, ROW_PREDICT, '0},
         '{-4096, 1, 48'h0000_0000_1004, 8'h99, 8'hAA, ROW_PREDICT, '0},
         '{-4096, 6, 48'h0000_0000_1005, 8'hBB, 8'hCC, ROW_PREDICT, '0},
         '{-4096, 2, 48'h0000_0000_1006, 8'hDD, 8'hEE, ROW_PREDICT, '0},
         '{-4096, 4, 48'h0000_0000_1007, 8'h01, 8'h02, ROW_NONE, '0},    // power-up tap rejected
         '{-4066, 1, TimeMax,            8'hFF, 8'h00, ROW_PREDICT, '0}, // exactly at start
         '{-4066, 0, 48'h5555_AAAA_5555, 8'h03, 8'h04, ROW_PREDICT, '0},
         '{-4066, 7, 48'hAAAA_5555_AAAA, 8'h05, 8'h06, ROW_PREDICT, '0},
         '{-4066, 2, 48'h0000_0000_2002, 8'h07, 8'h08, ROW_PREDICT, '0},
         '{-4066, 3, 48'h0000_0000_2003, 8'h09, 8'h0A, ROW_PREDICT, '0},
         '{-4066, 4, 48'h0000_0000_2004, 8'h0B, 8'h0C, ROW_PREDICT, '0},
         '{-4066, 5, 48'h0000_0000_2005, 8'h0D, 8'h0E, ROW_TAP, '{8'd1, TimeMax, 8'hFF, 8'h00}},
         '{-4037, 6, 48'h0000_0000_3000, 8'h10, 8'h20, ROW_PREDICT, '0}, // just below start
         '{ 4095, 7, 48'h0,              8'h00, 8'hFF, ROW_PREDICT, '0},
         '{ 4083, 0, 48'h0000_0000_3002, 8'h30, 8'h40, ROW_PREDICT, '0}, // exactly at quiet
         '{ 4094, 1, 48'h0000_0000_3003, 8'h50, 8'h60, ROW_PREDICT, '0},
         '{ 4094, 2, 48'h0000_0000_3004, 8'h70, 8'h80, ROW_PREDICT, '0},
         '{ 4094, 3, 48'h0000_0000_3005, 8'h90, 8'hA0, ROW_PREDICT, '0},
         '{ 4094, 4, 48'h0000_0000_3006, 8'hB0, 8'hC0, ROW_PREDICT, '0},
         '{ 4094, 5, 48'h0000_0000_3007, 8'hD0, 8'hE0, ROW_PREDICT, '0},
         '{ 4094, 6, 48'h0000_0000_3008, 8'hF0, 8'h0F, ROW_TAP, '{8'd2, 48'd0, 8'h00, 8'hFF}}
      };

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[k]) begin
         send_word(16'(dir_rows[k].level * 8 + dir_rows[k].low), dir_rows[k].t_ms,
                   dir_rows[k].x, dir_rows[k].y, got, tap);
         case (dir_rows[k].kind)
            ROW_TAP:     expected_taps.push_back(dir_rows[k].tap);
            ROW_NONE:    ;
            ROW_PREDICT: if (got) expected_taps.push_back(tap);
            default:     ;
         endcase
         shape_level = dir_rows[k].level;
      end
      settle();

      plan.push_back('{13'd0, 13'd8191, 8'd1, 8'd255});
      plan.push_back('{13'd8191, 13'd0, 8'd254, 8'd1});
      plan.push_back('{13'd20, 13'd10, 8'd0, 8'd0});
      plan.push_back('{13'd40, 13'd15, 8'd255, 8'd255});
      plan.push_back('{13'd1, 13'd1, 8'd1, 8'd2});
      repeat (6) begin
         ph.start_threshold = 13'($urandom_range(4, 300));
         ph.quiet_threshold = 13'($urandom_range(1, 40));
         ph.quiet_length = 8'($urandom_range(1, 12));
         ph.dur_limit = 8'($urandom_range(1, 70));
         plan.push_back(ph);
      end
      plan.push_back('{StartThresholdReset, QuietThresholdReset, QuietLengthReset,
                       MaxLengthReset});

      foreach (plan[i]) begin
         apply_settings(plan[i]);
         run_phase(PhaseWords);
      end

      if (mismatches == 0) begin
         $display("accel_tap_detector_unit regression: pass");
      end else begin
         $display("accel_tap_detector_unit regression: fail");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/atd_pkg.sv
hw/rtl/atd_csr.sv
hw/rtl/atd_core.sv
hw/rtl/accel_tap_detector_unit.sv
bench/testbench.sv
